[hw/rtl/fgr_pkg.sv]
// Shared constants, types and the 5x7 font table for the glyph rasterizer.
`default_nettype none

package fgr_pkg;

    // Screen geometry.
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    // Glyph geometry and printable code range.
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam int FIRST_CODE = 8'h20;
    localparam int LAST_CODE  = 8'h7E;
    localparam int GLYPH_NUM  = LAST_CODE - FIRST_CODE + 1;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_NUM);
    localparam int COL_W = $clog2(GLYPH_COLS);
    localparam int ROW_W = $clog2(GLYPH_ROWS);

    // Field widths.
    localparam int CODE_W  = 8;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 16;
    localparam int POS_W   = COORD_W + 1;

    // Stream payload widths.
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    // Screen bounds as signed values one bit wider than a coordinate, and the width unsigned at coordinate width.
    localparam logic signed [POS_W-1:0] WIDTH_S  = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] HEIGHT_S = POS_W'(SCREEN_HEIGHT);
    localparam logic [COORD_W-1:0]      WIDTH_U  = COORD_W'(SCREEN_WIDTH);

    // One pixel request from the sequencer to the pixel pipeline.
    typedef struct packed {
        logic                      valid;
        logic [CODE_W-1:0]         code;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [COLOR_W-1:0]        fg_color;
        logic [COLOR_W-1:0]        bg_color;
        logic                      last;
    } pix_req_t;

    // Font table: one entry per printable code, column 0 in the top byte.
    localparam logic [8*GLYPH_COLS-1:0] FONT_ROM [GLYPH_NUM] = '{
        40'h0000000000, 40'h00005F0000, 40'h0300030000, 40'h0A1F0A1F0A,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0000030000,
        40'h1C22410000, 40'h000041221C, 40'h2214081422, 40'h08087F0808,
        40'h0060200000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0036160000,
        40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h3E414D550E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h7F41410000,
        40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040,
        40'h0102000000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0808770000,
        40'h00007F0000, 40'h0000770808, 40'h0004030400
    };

    // Column byte of a glyph; blank for codes outside the printable range.
    function automatic logic [7:0] glyph_column(input logic [CODE_W-1:0] code,
                                                input logic [COL_W-1:0] col);
        logic [CODE_W-1:0]          idx;
        logic [8*GLYPH_COLS-1:0]    entry;
        logic [7:0]                 bits;
        idx  = code - CODE_W'(FIRST_CODE);
        bits = 8'h00;
        if (code >= CODE_W'(FIRST_CODE) && code <= CODE_W'(LAST_CODE) &&
            col < COL_W'(GLYPH_COLS)) begin
            entry = FONT_ROM[idx[GLYPH_IDX_W-1:0]];
            bits  = entry[8*(GLYPH_COLS-1-int'(col)) +: 8];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/font_glyph_rasterizer_top.sv]
// Top level of the 5x7 font glyph rasterizer with stream ports.
// The first pixel of a character passes the sequencer registers and pipeline stages 1, 2 and 3 before it appears.
// One pixel per cycle while the output is not stalled; the pixel sequencer steps through the 35 pixels of a character.
// A new character is accepted during the last pixel of the previous one, so no gaps occur.
// The whole pipeline stalls together while the output holds a pixel not yet taken.
// Reset (aresetn low, synchronous) empties the sequencer and all pipeline stages.
`default_nettype none

module font_glyph_rasterizer_top
    import fgr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // char_code[7:0], origin_x[23:8], origin_y[39:24], fg_color[47:40], bg_color[55:48]
    input  wire logic [S_DATA_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pixel_address[15:0], pixel_color[23:16]
    output logic [M_DATA_W-1:0]       m_tdata,
    // write_enable[0]
    output logic                      m_tuser,
    output logic                      m_tlast
);

    logic                 advance;
    logic                 can_load;
    logic                 load;
    pix_req_t             req;
    logic [ADDR_W-1:0]    pixel_address;
    logic [COLOR_W-1:0]   pixel_color;

    // The pipeline moves when its output register is empty or being drained.
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = can_load;
    assign load     = s_tvalid && can_load;

    fgr_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .advance   (advance),
        .char_code (s_tdata[7:0]),
        .origin_x  (s_tdata[23:8]),
        .origin_y  (s_tdata[39:24]),
        .fg_color  (s_tdata[47:40]),
        .bg_color  (s_tdata[55:48]),
        .req       (req),
        .can_load  (can_load)
    );

    fgr_pipe u_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .req           (req),
        .out_valid     (m_tvalid),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .write_enable  (m_tuser),
        .last_pixel    (m_tlast)
    );

    assign m_tdata = {pixel_color, pixel_address};

endmodule

`default_nettype wire

[hw/rtl/fgr_seq.sv]
// Pixel sequencer: holds one character request and steps through its 35 pixels.
`default_nettype none

module fgr_seq
    import fgr_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      load,
    input  wire logic                      advance,
    input  wire logic [CODE_W-1:0]         char_code,
    input  wire logic signed [COORD_W-1:0] origin_x,
    input  wire logic signed [COORD_W-1:0] origin_y,
    input  wire logic [COLOR_W-1:0]        fg_color,
    input  wire logic [COLOR_W-1:0]        bg_color,
    output pix_req_t                       req,
    output logic                           can_load
);

    logic                      busy_reg,  busy_next;
    logic [COL_W-1:0]          col_reg,   col_next;
    logic [ROW_W-1:0]          row_reg,   row_next;
    logic [CODE_W-1:0]         code_reg;
    logic signed [COORD_W-1:0] ox_reg;
    logic signed [COORD_W-1:0] oy_reg;
    logic [COLOR_W-1:0]        fg_reg;
    logic [COLOR_W-1:0]        bg_reg;
    logic                      last_pix;

    assign last_pix = (col_reg == COL_W'(GLYPH_COLS - 1)) &&
                      (row_reg == ROW_W'(GLYPH_ROWS - 1));

    // A new request may enter when idle or while the final pixel moves on.
    assign can_load = !busy_reg || (advance && last_pix);

    // Counter and busy update.
    always_comb begin
        busy_next = busy_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (load) begin
            busy_next = 1'b1;
            col_next  = '0;
            row_next  = '0;
        end else if (busy_reg && advance) begin
            if (last_pix) begin
                busy_next = 1'b0;
            end else if (row_reg == ROW_W'(GLYPH_ROWS - 1)) begin
                row_next = '0;
                col_next = col_reg + COL_W'(1);
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // Character fields are captured with the request.
    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= char_code;
            ox_reg   <= origin_x;
            oy_reg   <= origin_y;
            fg_reg   <= fg_color;
            bg_reg   <= bg_color;
        end
    end

    always_comb begin
        req.valid    = busy_reg;
        req.code     = code_reg;
        req.col      = col_reg;
        req.row      = row_reg;
        req.origin_x = ox_reg;
        req.origin_y = oy_reg;
        req.fg_color = fg_reg;
        req.bg_color = bg_reg;
        req.last     = last_pix;
    end

endmodule

`default_nettype wire

[hw/rtl/fgr_pipe.sv]
// Pixel pipeline: font lookup and coordinates, clipping and multiply, address.
`default_nettype none

module fgr_pipe
    import fgr_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire pix_req_t            req,
    output logic                     out_valid,
    output logic [ADDR_W-1:0]        pixel_address,
    output logic [COLOR_W-1:0]       pixel_color,
    output logic                     write_enable,
    output logic                     last_pixel
);

    // Stage 1: font bit, color choice and pixel coordinates.
    logic                    s1_valid_reg;
    logic signed [POS_W-1:0] s1_x_reg, s1_x_next;
    logic signed [POS_W-1:0] s1_y_reg, s1_y_next;
    logic [COLOR_W-1:0]      s1_color_reg, s1_color_next;
    logic                    s1_last_reg;
    logic [7:0]              col_bits;

    always_comb begin
        col_bits      = glyph_column(req.code, req.col);
        s1_color_next = col_bits[req.row] ? req.fg_color : req.bg_color;
        s1_x_next     = POS_W'(req.origin_x) + $signed({{(POS_W-COL_W){1'b0}}, req.col});
        s1_y_next     = POS_W'(req.origin_y) + $signed({{(POS_W-ROW_W){1'b0}}, req.row});
    end

    // Stage 2: on-screen test and row base address.
    logic                      s2_valid_reg;
    logic                      s2_on_reg,    s2_on_next;
    logic [ADDR_W-1:0]         s2_base_reg,  s2_base_next;
    logic [ADDR_W-1:0]         s2_x_reg;
    logic [COLOR_W-1:0]        s2_color_reg;
    logic                      s2_last_reg;
    logic [2*COORD_W-1:0]      product;

    always_comb begin
        s2_on_next   = !s1_x_reg[POS_W-1] && !s1_y_reg[POS_W-1] &&
                       (s1_x_reg < WIDTH_S) && (s1_y_reg < HEIGHT_S);
        product      = {{COORD_W{1'b0}}, s1_y_reg[COORD_W-1:0]} *
                       {{COORD_W{1'b0}}, WIDTH_U};
        s2_base_next = product[ADDR_W-1:0];
    end

    // Stage 3: final address, clipped pixels carry address zero.
    logic                  s3_valid_reg;
    logic [ADDR_W-1:0]     s3_addr_reg, s3_addr_next;
    logic [COLOR_W-1:0]    s3_color_reg;
    logic                  s3_we_reg;
    logic                  s3_last_reg;

    assign s3_addr_next = s2_on_reg ? (s2_base_reg + s2_x_reg) : '0;

    // Valid bits move with the data whenever the output side can advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_x_reg     <= s1_x_next;
            s1_y_reg     <= s1_y_next;
            s1_color_reg <= s1_color_next;
            s1_last_reg  <= req.last;
            s2_on_reg    <= s2_on_next;
            s2_base_reg  <= s2_base_next;
            s2_x_reg     <= s1_x_reg[ADDR_W-1:0];
            s2_color_reg <= s1_color_reg;
            s2_last_reg  <= s1_last_reg;
            s3_addr_reg  <= s3_addr_next;
            s3_color_reg <= s2_color_reg;
            s3_we_reg    <= s2_on_reg;
            s3_last_reg  <= s2_last_reg;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign pixel_address = s3_addr_reg;
    assign pixel_color   = s3_color_reg;
    assign write_enable  = s3_we_reg;
    assign last_pixel    = s3_last_reg;

endmodule

`default_nettype wire

[sim/tb_font_glyph_rasterizer_top.sv]
// Self-checking stream testbench for the 5x7 glyph rasterizer top level.
`timescale 1ns / 1ps

package glyph_check_pkg;

    // Screen size that the block is built for.
    localparam int DISP_W = 320;
    localparam int DISP_H = 200;

    // Printable code range and glyph shape.
    localparam logic [7:0] CODE_LO = 8'h20;
    localparam logic [7:0] CODE_HI = 8'h7E;
    localparam int COLS = 5;
    localparam int ROWS = 7;

    // Column bytes of each printable glyph, column 0 in the top byte.
    localparam logic [39:0] GLYPH_FONT [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0300030000, 40'h0A1F0A1F0A,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0000030000,
        40'h1C22410000, 40'h000041221C, 40'h2214081422, 40'h08087F0808,
        40'h0060200000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0036160000,
        40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h3E414D550E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h7F41410000,
        40'h0204081020, 40'h000041417F, 40'h0402010204, 40'h4040404040,
        40'h0102000000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0808770000,
        40'h00007F0000, 40'h0000770808, 40'h0004030400
    };

    // One character cell as the sender presents it.
    typedef struct {
        logic [7:0]         code;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic [7:0]         fg;
        logic [7:0]         bg;
    } char_cell_t;

    // One pixel write as the block returns it.
    typedef struct {
        logic [15:0] addr;
        logic [7:0]  color;
        logic        we;
        logic        last;
    } pixel_write_t;

    class pixel_write_tracker;
        pixel_write_t pending_writes[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_writes.size();
        endfunction

        // Expands an accepted character into its 35 pixel writes, column by column.
        function void add_char(char_cell_t chr);
            logic [39:0]  glyph;
            logic [7:0]   col_bits;
            int           px;
            int           py;
            bit           on_screen;
            pixel_write_t w;
            glyph = '0;
            if (chr.code >= CODE_LO && chr.code <= CODE_HI) begin
                glyph = GLYPH_FONT[int'(chr.code) - int'(CODE_LO)];
            end
            for (int c = 0; c < COLS; c++) begin
                col_bits = glyph[8*(COLS-1-c) +: 8];
                for (int r = 0; r < ROWS; r++) begin
                    px = int'(chr.ox) + c;
                    py = int'(chr.oy) + r;
                    on_screen = px >= 0 && py >= 0 && px < DISP_W && py < DISP_H;
                    w.addr  = on_screen ? 16'(py * DISP_W + px) : 16'h0000;
                    w.color = col_bits[r] ? chr.fg : chr.bg;
                    w.we    = on_screen;
                    w.last  = (c == COLS - 1) && (r == ROWS - 1);
                    pending_writes.push_back(w);
                end
            end
        endfunction

        // Compares one returned pixel write against the oldest outstanding one.
        function void take_pixel(logic [15:0] addr, logic [7:0] color, logic we, logic last);
            pixel_write_t want;
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected pixel: addr %h color %h we %b last %b",
                             addr, color, we, last);
                end
                return;
            end
            want = pending_writes.pop_front();
            if (addr !== want.addr || color !== want.color ||
                we !== want.we || last !== want.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("pixel mismatch: want addr %h color %h we %b last %b",
                             want.addr, want.color, want.we, want.last);
                    $display("                 got addr %h color %h we %b last %b",
                             addr, color, we, last);
                end
            end
        endfunction
    endclass

endpackage

module tb_font_glyph_rasterizer_top
    import fgr_pkg::*;
    import glyph_check_pkg::*;
();

    localparam int RAND_CHARS = 470;

    // Receiver stall behaviors.
    typedef enum int {
        RX_OPEN,
        RX_LIGHT_STALL,
        RX_HEAVY_STALL,
        RX_PERIODIC
    } rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    pixel_write_tracker tracker = new();

    font_glyph_rasterizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic char_cell_t make_cell(logic [7:0] code, int x, int y,
                                             logic [7:0] fg, logic [7:0] bg);
        char_cell_t chr;
        chr.code = code;
        chr.ox   = 16'(x);
        chr.oy   = 16'(y);
        chr.fg   = fg;
        chr.bg   = bg;
        return chr;
    endfunction

    // Random cell: mostly printable and on screen, with edges and wild origins mixed in.
    function automatic char_cell_t random_cell();
        char_cell_t chr;
        int         place;
        place = $urandom_range(0, 9);
        chr.code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(32, 126));
        if (place == 0) begin
            chr.ox = 16'($urandom);
            chr.oy = 16'($urandom);
        end else if (place <= 2) begin
            chr.ox = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8) - 6)
                                                 : 16'($urandom_range(314, 322));
            chr.oy = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 10) - 8)
                                                 : 16'($urandom_range(192, 202));
        end else begin
            chr.ox = 16'($urandom_range(0, 315));
            chr.oy = 16'($urandom_range(0, 193));
        end
        chr.fg = 8'($urandom_range(0, 255));
        chr.bg = 8'($urandom_range(0, 255));
        return chr;
    endfunction

    // Presents one character and holds it until the block takes the request.
    task automatic send_char(input char_cell_t chr);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {chr.bg, chr.fg, chr.oy, chr.ox, chr.code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.add_char(chr);
    endtask

    // Sender idles with junk on the data bus.
    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = S_DATA_W'({$urandom, $urandom});
        end
    endtask

    task automatic drain_pixels();
        idle_gap(1);
        while (tracker.outstanding() != 0) @(posedge aclk);
    endtask

    // Receiver switches between stall behaviors, holding each one for a random span.
    initial begin
        rx_mode_t mode;
        int       span;
        int       beat;
        beat = 0;
        forever begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(40, 300);
            repeat (span) begin
                @(negedge aclk);
                beat++;
                case (mode)
                    RX_OPEN:        m_tready = 1'b1;
                    RX_LIGHT_STALL: m_tready = ($urandom_range(0, 3) != 0);
                    RX_HEAVY_STALL: m_tready = ($urandom_range(0, 3) == 0);
                    default:        m_tready = ((beat % 7) < 3);
                endcase
            end
        end
    end

    // Every accepted pixel goes to the tracker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.take_pixel(m_tdata[15:0], m_tdata[23:16], m_tuser, m_tlast);
        end
    end

    // Stimulus and end of run.
    initial begin
        int  sent;
        int  burst;
        bit  drained;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed cells: glyph shapes, blank codes, clipping on all sides, extreme origins.
        send_char(make_cell(8'h41, 0, 0, 8'hFF, 8'h00));
        send_char(make_cell(8'h61, 10, 10, 8'h00, 8'hFF));
        send_char(make_cell(8'h30, 100, 50, 8'hAA, 8'h55));
        send_char(make_cell(8'h21, 315, 193, 8'h0F, 8'hF0));
        send_char(make_cell(8'h20, 319, 199, 8'h12, 8'h34));
        send_char(make_cell(8'h00, 5, 5, 8'hFF, 8'h01));
        send_char(make_cell(8'h1F, 6, 7, 8'h80, 8'h7F));
        send_char(make_cell(8'h7F, 50, 60, 8'h33, 8'hCC));
        send_char(make_cell(8'h80, 51, 61, 8'h44, 8'hBB));
        send_char(make_cell(8'hFF, 52, 62, 8'hFE, 8'h01));
        send_char(make_cell(8'h7E, 200, 100, 8'h5A, 8'hA5));
        send_char(make_cell(8'h23, -4, -6, 8'hC3, 8'h3C));
        send_char(make_cell(8'h24, 316, 194, 8'h96, 8'h69));
        send_char(make_cell(8'h40, -5, -7, 8'h11, 8'hEE));
        send_char(make_cell(8'h5A, -32768, -32768, 8'hFF, 8'hFF));
        send_char(make_cell(8'h7A, 32767, 32767, 8'h00, 8'h00));
        send_char(make_cell(8'h2A, 320, 0, 8'h22, 8'hDD));
        send_char(make_cell(8'h2B, 0, 200, 8'h77, 8'h88));
        send_char(make_cell(8'h26, -1, 100, 8'h01, 8'hFE));
        send_char(make_cell(8'h25, 200, -1, 8'hF0, 8'h0F));
        send_char(make_cell(8'h57, 32767, -32768, 8'h3C, 8'hC3));
        send_char(make_cell(8'h67, -32768, 32767, 8'h55, 8'hAA));
        drain_pixels();

        // Random bursts with random gaps; one full drain half way through.
        sent    = 0;
        drained = 1'b0;
        while (sent < RAND_CHARS) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < RAND_CHARS) begin
                send_char(random_cell());
                sent++;
                burst--;
            end
            if (!drained && sent >= RAND_CHARS / 2) begin
                drain_pixels();
                drained = 1'b1;
            end
            idle_gap(($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                 : $urandom_range(0, 8));
        end
        idle_gap(1);

        // Let the last pixels out, then watch for strays.
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/fgr_pkg.sv
hw/rtl/fgr_seq.sv
hw/rtl/fgr_pipe.sv
hw/rtl/font_glyph_rasterizer_top.sv
sim/tb_font_glyph_rasterizer_top.sv
